@@ rtl/ppm_header_parser_assert.svh @@
// assertion macros shared by the checker of the header parser
// no dependencies; take in by include where assertions are written
`ifndef PPM_HEADER_PARSER_ASSERT_SVH
`define PPM_HEADER_PARSER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal must keep its value in the cycle after cond
`define PPM_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ rtl/ppm_hdr_pkg.sv @@
// types, codes and constants of the ppm header parser
// no dependencies; imported by every module and interface of the block
`default_nettype none

package ppm_hdr_pkg;

  // header bytes that must hold every field
  localparam int unsigned HeaderLimit = 40;

  localparam int unsigned PosW    = 6;
  localparam int unsigned DimW    = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned StatW   = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegMinDim = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxDim = CfgIdxW'(1);

  localparam logic [DimW-1:0] MinDimReset = DimW'(1);
  localparam logic [DimW-1:0] MaxDimReset = DimW'(4096);

  // characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch6     = 8'h36;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChP     = 8'h50;

  localparam logic [AccW-1:0] AccSat    = 32'h8000_0000;
  localparam logic [AccW-1:0] PosMax    = 32'h7FFF_FFFF;
  localparam logic [AccW-1:0] MaxvalOk  = 32'd255;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_MALFORMED  = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_RES    = 3'd3,
    ST_BAD_MAXVAL = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FLD_MAGIC  = 2'd0,
    FLD_WIDTH  = 2'd1,
    FLD_HEIGHT = 2'd2,
    FLD_MAXVAL = 2'd3
  } field_e;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_STOP   = 2'd2
  } num_phase_e;

  // state of the number being read
  typedef struct packed {
    num_phase_e      phase;
    logic            neg;
    logic [AccW-1:0] acc;
  } num_t;

  localparam num_t NumClear = '{phase: NUM_SKIP, neg: 1'b0, acc: '0};

  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       first_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    status_e         status;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic [PosW-1:0] data_offset;
  } res_t;

  typedef struct packed {
    logic [DimW-1:0] min_dim;
    logic [DimW-1:0] max_dim;
  } dim_cfg_t;

endpackage

`default_nettype wire

@@ rtl/ppm_hdr_if.sv @@
// valid/ready channels of the ppm header parser: byte input, result, config write
// depends on ppm_hdr_pkg
`default_nettype none

interface ppm_hdr_in_if import ppm_hdr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] hdr_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output hdr_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input hdr_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface ppm_hdr_out_if import ppm_hdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [DimW-1:0]  image_width;
  logic [DimW-1:0]  image_height;
  logic [PosW-1:0]  data_offset;

  modport source (output valid, output status, output image_width, output image_height,
                  output data_offset, input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  input data_offset, output ready);
endinterface

interface ppm_hdr_cfg_if import ppm_hdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/ppm_hdr_cfg.sv @@
// configuration registers: smallest and largest accepted image dimension
// depends on ppm_hdr_pkg and ppm_hdr_cfg_if
`default_nettype none

module ppm_hdr_cfg import ppm_hdr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ppm_hdr_cfg_if.sink   cfg_i,
  output dim_cfg_t      dims_o
);

  logic [DimW-1:0] min_dim_q, min_dim_d;
  logic [DimW-1:0] max_dim_q, max_dim_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    min_dim_d = min_dim_q;
    max_dim_d = max_dim_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == RegMinDim) begin
        min_dim_d = cfg_i.data;
      end
      if (cfg_i.index == RegMaxDim) begin
        max_dim_d = cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dim_q <= MinDimReset;
      max_dim_q <= MaxDimReset;
    end else begin
      min_dim_q <= min_dim_d;
      max_dim_q <= max_dim_d;
    end
  end

  assign dims_o = '{min_dim: min_dim_q, max_dim: max_dim_q};

endmodule

`default_nettype wire

@@ rtl/ppm_hdr_num.sv @@
// decimal reader: one byte step of an atoi style number and its signed value
// depends on ppm_hdr_pkg
`default_nettype none

module ppm_hdr_num import ppm_hdr_pkg::*; (
  input  num_t            num_i,
  input  wire logic [7:0] byte_i,
  output num_t            num_o,
  output logic [AccW-1:0] value_o
);

  logic              is_digit;
  logic              is_space;
  logic              is_sign;
  logic [3:0]        digit;
  logic [AccW+2:0]   acc_x10;
  logic [AccW-1:0]   acc_sat;
  logic [7:0]        digit_ofs;

  // byte classes
  assign is_digit  = (byte_i >= Ch0) && (byte_i <= Ch9);
  assign is_space  = (byte_i == ChSpace) || ((byte_i >= ChTab) && (byte_i <= ChCr));
  assign is_sign   = (byte_i == ChPlus) || (byte_i == ChMinus);
  assign digit_ofs = byte_i - Ch0;
  assign digit     = digit_ofs[3:0];

  // acc * 10 + digit, saturating at 2^31
  assign acc_x10 = ({3'b000, num_i.acc} << 3) + ({3'b000, num_i.acc} << 1)
                 + (AccW+3)'(digit);
  assign acc_sat = (acc_x10 > (AccW+3)'(AccSat)) ? AccSat : acc_x10[AccW-1:0];

  // phase sequencing
  always_comb begin
    num_o = num_i;
    unique case (num_i.phase)
      NUM_SKIP: begin
        if (is_space) begin
          num_o = num_i;
        end else if (is_sign) begin
          num_o.neg   = (byte_i == ChMinus);
          num_o.phase = NUM_DIGITS;
        end else if (is_digit) begin
          num_o.acc   = acc_sat;
          num_o.phase = NUM_DIGITS;
        end else begin
          num_o.phase = NUM_STOP;
        end
      end
      NUM_DIGITS: begin
        if (is_digit) begin
          num_o.acc = acc_sat;
        end else begin
          num_o.phase = NUM_STOP;
        end
      end
      default: begin
        num_o = num_i;
      end
    endcase
  end

  // signed 32-bit value, positive side clamped
  always_comb begin
    if (num_i.neg) begin
      value_o = AccW'(0) - num_i.acc;
    end else if (num_i.acc[AccW-1]) begin
      value_o = PosMax;
    end else begin
      value_o = num_i.acc;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppm_hdr_parse.sv @@
// header parse state: field split, magic check, limits and result decision
// depends on ppm_hdr_pkg and ppm_hdr_num
`default_nettype none

module ppm_hdr_parse import ppm_hdr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  beat_t     beat_i,
  input  dim_cfg_t  dims_i,
  output logic      emit_o,
  output res_t      res_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_cur;
  field_e          fld_q, fld_d, fld_cur;
  num_t            num_q, num_d, num_cur, num_next;
  logic [AccW-1:0] width_q, width_d, width_cur;
  logic [AccW-1:0] height_q, height_d, height_cur;
  logic            magic_q, magic_d, magic_cur;
  logic            done_q, done_d, done_cur;

  logic [7:0]      hb;
  logic [AccW-1:0] num_value;
  logic [7:0]      sep;
  logic            closing;
  logic            magic_bad;
  logic            complete;

  function automatic logic dim_ok(input logic [AccW-1:0] v, input dim_cfg_t c);
    return !v[AccW-1] && (v >= AccW'(c.min_dim)) && (v <= AccW'(c.max_dim));
  endfunction

  assign hb = beat_i.hdr_byte;

  // a first byte restarts the parse before it is used
  always_comb begin
    if (beat_i.first_byte) begin
      pos_cur    = '0;
      fld_cur    = FLD_MAGIC;
      num_cur    = NumClear;
      width_cur  = '0;
      height_cur = '0;
      magic_cur  = 1'b1;
      done_cur   = 1'b0;
    end else begin
      pos_cur    = pos_q;
      fld_cur    = fld_q;
      num_cur    = num_q;
      width_cur  = width_q;
      height_cur = height_q;
      magic_cur  = magic_q;
      done_cur   = done_q;
    end
  end

  ppm_hdr_num u_num (
    .num_i   (num_cur),
    .byte_i  (hb),
    .num_o   (num_next),
    .value_o (num_value)
  );

  // field terminator and magic bytes
  assign sep       = (fld_cur == FLD_WIDTH) ? ChSpace : ChLf;
  assign closing   = (hb == sep) || (hb == ChNul);
  assign magic_bad = ((pos_cur == PosW'(0)) && (hb != ChP))
                  || ((pos_cur == PosW'(1)) && (hb != Ch6))
                  || ((pos_cur == PosW'(2)) && (hb != ChLf));

  // next state and result
  always_comb begin
    pos_d    = pos_cur;
    fld_d    = fld_cur;
    num_d    = num_cur;
    width_d  = width_cur;
    height_d = height_cur;
    magic_d  = magic_cur;
    done_d   = done_cur;
    complete = 1'b0;
    emit_o   = 1'b0;
    res_o    = '{status: ST_OK, image_width: '0, image_height: '0, data_offset: '0};
    if (!done_cur) begin
      magic_d = magic_cur & ~magic_bad;
      pos_d   = pos_cur + PosW'(1);
      if (closing) begin
        unique case (fld_cur)
          FLD_MAGIC:  complete = 1'b0;
          FLD_WIDTH:  width_d  = num_value;
          FLD_HEIGHT: height_d = num_value;
          FLD_MAXVAL: complete = 1'b1;
          default:    complete = 1'b0;
        endcase
        fld_d = field_e'(fld_cur + 2'd1);
        num_d = NumClear;
      end else if (fld_cur != FLD_MAGIC) begin
        num_d = num_next;
      end
      if (complete) begin
        done_d = 1'b1;
        emit_o = 1'b1;
        priority if (!magic_d) begin
          res_o.status = ST_BAD_MAGIC;
        end else if (!dim_ok(width_cur, dims_i) || !dim_ok(height_cur, dims_i)) begin
          res_o.status = ST_BAD_RES;
        end else if (num_value != MaxvalOk) begin
          res_o.status = ST_BAD_MAXVAL;
        end else begin
          res_o.status       = ST_OK;
          res_o.image_width  = width_cur[DimW-1:0];
          res_o.image_height = height_cur[DimW-1:0];
          res_o.data_offset  = pos_d;
        end
      end else if ((pos_d >= PosW'(HeaderLimit)) || beat_i.last_byte) begin
        done_d       = 1'b1;
        emit_o       = 1'b1;
        res_o.status = ST_MALFORMED;
      end
    end
  end

  // state advances only on a consumed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fld_q    <= FLD_MAGIC;
      num_q    <= NumClear;
      width_q  <= '0;
      height_q <= '0;
      magic_q  <= 1'b1;
      done_q   <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      fld_q    <= fld_d;
      num_q    <= num_d;
      width_q  <= width_d;
      height_q <= height_d;
      magic_q  <= magic_d;
      done_q   <= done_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppm_header_parser.sv @@
// Binary PPM header parser. Takes one file byte per beat on hdr_i and gives one result
// beat per file on res_o: status, width, height and pixel data offset. A byte is taken
// every cycle unless the input stalls. The closing byte's result passes the byte input
// register, which feeds the parse state and the result register through combinational
// logic whose longest path is the decimal accumulate (times ten plus digit) and the
// dimension compares, and then the output register. The input stalls only when a byte
// that ends the parse finds the output register still full and not being taken.
// Config writes on cfg_i (index 0 min dimension, 1 max dimension) must come while idle.
// depends on ppm_hdr_pkg, the channel interfaces, ppm_hdr_cfg and ppm_hdr_parse
`default_nettype none

module ppm_header_parser import ppm_hdr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ppm_hdr_in_if.sink    hdr_i,
  ppm_hdr_out_if.source res_o,
  ppm_hdr_cfg_if.sink   cfg_i
);

  logic     in_valid_q, in_valid_d;
  beat_t    in_beat_q;
  logic     out_valid_q, out_valid_d;
  res_t     out_res_q;
  logic     in_take;
  logic     advance;
  logic     emit;
  res_t     res;
  dim_cfg_t dims;

  ppm_hdr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .dims_o (dims)
  );

  ppm_hdr_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .beat_i (in_beat_q),
    .dims_i (dims),
    .emit_o (emit),
    .res_o  (res)
  );

  // flow control: the held byte moves on unless its result would collide
  assign advance     = in_valid_q && (!emit || !out_valid_q || res_o.ready);
  assign hdr_i.ready = !in_valid_q || advance;
  assign in_take     = hdr_i.valid && hdr_i.ready;

  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_comb begin
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q <= '{hdr_byte: hdr_i.hdr_byte, first_byte: hdr_i.first_byte,
                     last_byte: hdr_i.last_byte};
    end
    if (advance && emit) begin
      out_res_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_res_q.status;
  assign res_o.image_width  = out_res_q.image_width;
  assign res_o.image_height = out_res_q.image_height;
  assign res_o.data_offset  = out_res_q.data_offset;

endmodule

`default_nettype wire

@@ rtl/ppm_hdr_checker.sv @@
// port level checks of the ppm header parser, bound to the top level
// depends on ppm_hdr_pkg and ppm_header_parser_assert.svh
`default_nettype none

`include "ppm_header_parser_assert.svh"

module ppm_hdr_checker import ppm_hdr_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire logic [StatW-1:0] res_status,
  input wire logic [DimW-1:0]  res_width,
  input wire logic [DimW-1:0]  res_height,
  input wire logic [PosW-1:0]  res_offset
);

  logic res_ok;
  logic res_fail;

  assign res_ok   = res_valid && (res_status == ST_OK);
  assign res_fail = res_valid && (res_status != ST_OK);

  // a stalled result beat keeps its contents
  `PPM_ASSERT_HOLD(a_res_hold, clk_i, rst_ni, res_valid && !res_ready,
    {res_valid, res_status, res_width, res_height, res_offset}, "result beat changed while stalled")

  // a new result rises only after a byte beat was taken
  `PPM_ASSERT(a_res_cause, clk_i, rst_ni, $rose(res_valid) |-> $past(in_valid && in_ready, 2),
    "result without a byte beat before it")

  // failed parses report no geometry
  `PPM_ASSERT(a_fail_zero, clk_i, rst_ni,
    res_fail |-> (res_width == '0) && (res_height == '0) && (res_offset == '0),
    "nonzero fields on failed header")

  // a good header is at least nine bytes and within the limit
  `PPM_ASSERT(a_ok_offset, clk_i, rst_ni,
    res_ok |-> (res_offset >= PosW'(9)) && (res_offset <= PosW'(HeaderLimit)),
    "data offset out of range on good header")

endmodule

bind ppm_header_parser ppm_hdr_checker u_ppm_hdr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (hdr_i.valid),
  .in_ready   (hdr_i.ready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_status (res_o.status),
  .res_width  (res_o.image_width),
  .res_height (res_o.image_height),
  .res_offset (res_o.data_offset)
);

`default_nettype wire
